// File: design/mlbf_pkg.sv
// ----------------------------------------------------------------------------
// mlbf_pkg: shared types and constants for the learning bridge forwarder
// Field widths, stream packing sizes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package mlbf_pkg;

  localparam int MAC_W          = 48;
  localparam int PORT_W         = 3;
  localparam int MASK_W         = 8;
  localparam int CFG_W          = 4;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int PORT_MAX_DEF    = 8;

  localparam logic [CFG_W-1:0] PORT_COUNT_RST = CFG_W'(2);

  // in_tdata: src_mac, dest_mac, ingress_port, zero pad to whole bytes
  localparam int IN_FIELDS_W = 2 * MAC_W + PORT_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = MASK_W;

  // result flags, lowest bit first: dest_known, learned_new, port_moved, table_full
  typedef struct packed {
    logic table_full;
    logic port_moved;
    logic learned_new;
    logic dest_known;
  } out_flags_t;

  localparam int OUT_TUSER_W = $bits(out_flags_t);

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// File: design/mlbf_ram.sv
// ----------------------------------------------------------------------------
// mlbf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/mac_learning_bridge_forwarder.sv
// ----------------------------------------------------------------------------
// mac_learning_bridge_forwarder: Ethernet learning bridge with MAC table
// Learns the source address, then forwards on the destination address.
// ----------------------------------------------------------------------------
// Flow: one read per valid entry (fill_count reads, none on an empty table), each
//   entry compared as its read data arrives, a closing step, then one update.
// The update waits for a free output register. The next header is taken only
//   back in idle; the scan runs through the single table read port.
// Reset: fill_count cleared, so the table is empty at once (index < fill_count
//   means valid); port_count returns to 2. No clearing pass.
// ----------------------------------------------------------------------------
module mac_learning_bridge_forwarder #(
  parameter int TABLE_DEPTH = mlbf_pkg::TABLE_DEPTH_DEF,
  parameter int PORT_MAX    = mlbf_pkg::PORT_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: port_count
  input  logic                              cfg_wr_en,
  input  logic [mlbf_pkg::CFG_W-1:0]        cfg_wr_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: [47:0] src_mac, [95:48] dest_mac, [98:96] ingress_port, rest zero
  input  logic [mlbf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: [7:0] egress_mask
  output logic [mlbf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: [0] dest_known, [1] learned_new, [2] port_moved, [3] table_full
  output logic [mlbf_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  import mlbf_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // fill count reaches TABLE_DEPTH

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    port_count_r;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;       // next entry to read
  logic                pend_r, pend_nxt;     // read data arrives this cycle
  logic [AW-1:0]       pidx_r;               // index of the arriving entry

  // captured header (payload, no reset)
  logic [MAC_W-1:0]    src_r, dst_r;
  logic [PORT_W-1:0]   ing_r;

  // scan results
  logic                s_hit_r, s_hit_nxt;
  logic [AW-1:0]       s_idx_r, s_idx_nxt;
  logic [PORT_W-1:0]   s_port_r, s_port_nxt;
  logic                d_hit_r, d_hit_nxt;
  logic [PORT_W-1:0]   d_port_r, d_port_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]   out_mask_r, out_mask_nxt;
  out_flags_t          out_flags_r, out_flags_nxt;

  // RAM port signals
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  // shared match unit outputs
  logic                src_match, dst_match;

  logic                in_acc;
  logic                out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = out_flags_r;

  // --------------------------------------------------------------------------
  // Table RAM: {port, mac} per entry
  // --------------------------------------------------------------------------
  mlbf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared match unit: one entry against both keys per cycle.
  assign src_match = (ram_rdata.mac == src_r);
  assign dst_match = (ram_rdata.mac == dst_r);

  // --------------------------------------------------------------------------
  // Forwarding decision (used in the update cycle)
  // --------------------------------------------------------------------------
  logic [MASK_W-1:0]   ports_mask;
  logic [MASK_W-1:0]   ing_bit;
  logic                same_mac;
  logic                will_learn;
  logic                is_full;
  logic                will_move;
  logic                dst_known;
  logic [PORT_W-1:0]   dst_port;
  logic [MASK_W-1:0]   fwd_mask;

  // configured ports: p below port_count and below PORT_MAX
  always_comb begin
    for (int p = 0; p < MASK_W; p++) begin
      ports_mask[p] = (p < PORT_MAX) && (CFG_W'(p) < port_count_r);
    end
  end

  assign ing_bit    = MASK_W'(1) << ing_r;
  assign same_mac   = (src_r == dst_r);
  assign will_learn = !s_hit_r && (fill_r < CW'(TABLE_DEPTH));
  assign is_full    = !s_hit_r && !will_learn;
  assign will_move  = s_hit_r && (s_port_r != ing_r);

  // Destination equal to source sees the updated entry on the ingress port.
  assign dst_known = d_hit_r || (same_mac && will_learn);
  assign dst_port  = same_mac ? ing_r : d_port_r;

  always_comb begin
    if (!dst_known) begin
      fwd_mask = ports_mask & ~ing_bit;     // flood
    end else if (dst_port == ing_r) begin
      fwd_mask = '0;                        // filtered
    end else begin
      fwd_mask = ports_mask & (MASK_W'(1) << dst_port);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    s_hit_nxt     = s_hit_r;
    s_idx_nxt     = s_idx_r;
    s_port_nxt    = s_port_r;
    d_hit_nxt     = d_hit_r;
    d_port_nxt    = d_port_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mask_nxt  = out_mask_r;
    out_flags_nxt = out_flags_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];
    ram_we        = 1'b0;
    ram_waddr     = s_idx_r;
    ram_wdata     = '{port: ing_r, mac: src_r};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt   = '0;
          s_hit_nxt = 1'b0;
          d_hit_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue a read for every valid entry
        if (idx_r < fill_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
        // compare the entry read last cycle
        if (pend_r) begin
          if (src_match && !s_hit_r) begin
            s_hit_nxt  = 1'b1;
            s_idx_nxt  = pidx_r;
            s_port_nxt = ram_rdata.port;
          end
          if (dst_match && !d_hit_r) begin
            d_hit_nxt  = 1'b1;
            d_port_nxt = ram_rdata.port;
          end
        end
        if (!(idx_r < fill_r) && !pend_r) begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        if (out_free) begin
          if (will_learn) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[AW-1:0];
            fill_nxt  = fill_r + CW'(1);
          end else if (will_move) begin
            ram_we    = 1'b1;
            ram_waddr = s_idx_r;
          end
          out_valid_nxt             = 1'b1;
          out_mask_nxt              = fwd_mask;
          out_flags_nxt.dest_known  = dst_known;
          out_flags_nxt.learned_new = will_learn;
          out_flags_nxt.port_moved  = will_move;
          out_flags_nxt.table_full  = is_full;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      port_count_r <= PORT_COUNT_RST;
      fill_r       <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        port_count_r <= cfg_wr_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload and scan registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r <= in_tdata[MAC_W-1:0];
      dst_r <= in_tdata[2*MAC_W-1:MAC_W];
      ing_r <= in_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
    end
    idx_r       <= idx_nxt;
    pidx_r      <= idx_r[AW-1:0];
    s_hit_r     <= s_hit_nxt;
    s_idx_r     <= s_idx_nxt;
    s_port_r    <= s_port_nxt;
    d_hit_r     <= d_hit_nxt;
    d_port_r    <= d_port_nxt;
    out_mask_r  <= out_mask_nxt;
    out_flags_r <= out_flags_nxt;
  end

endmodule

// File: bench/mac_learning_bridge_forwarder_tb.sv
// ----------------------------------------------------------------------------
// mac_learning_bridge_forwarder_tb: self-checking bench for the learning bridge
// Streams frame headers through the forwarder and checks every egress mask and
// flag against a behavioral MAC table kept in the bench. Covers learning,
// station moves, flood, unicast, drop, a full table and port counts 0 to 9 and 15.
// ----------------------------------------------------------------------------
module mac_learning_bridge_forwarder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlbf_pkg::*;

  localparam int TBL_DEPTH      = TABLE_DEPTH_DEF;
  localparam int PORTS          = PORT_MAX_DEF;
  localparam int IDLE_PCT       = 22;        // per-cycle idle odds on each side
  localparam int RAND_PER_PHASE = 157;       // 12 phases, about 1900 headers total
  localparam int POOL_MAX       = 120;       // more addresses than table entries
  localparam int HOLD_AT        = 560;       // long receiver hold-off starts here
  localparam int HOLD_CYCLES    = 400;
  localparam int STEADY_LO      = 1000;      // no idling on either side in this
  localparam int STEADY_HI      = 1250;      //   window of accepted headers
  localparam int DRAIN_TAIL     = TBL_DEPTH + 16;  // worst-case scan plus margin
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int REPORT_MAX     = 10;

  // Header as it sits in in_tdata: src_mac lowest, then dest_mac, then port
  typedef struct packed {
    logic [PORT_W-1:0] ingress;
    logic [MAC_W-1:0]  dest;
    logic [MAC_W-1:0]  src;
  } frame_hdr_t;

  typedef struct packed {
    out_flags_t        flags;
    logic [MASK_W-1:0] egress_mask;
  } fwd_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  mac_learning_bridge_forwarder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral MAC table. Mirrors the bridge: learn source, then forward on
  // destination against the updated table. Entries fill from 0 upward and
  // are never aged out, so once full every new source is refused for good.
  // --------------------------------------------------------------------------
  logic             tbl_valid [TBL_DEPTH];
  logic [MAC_W-1:0] tbl_mac   [TBL_DEPTH];
  logic [PORT_W-1:0] tbl_port [TBL_DEPTH];
  int               tbl_fill = 0;
  logic [CFG_W-1:0] port_count_cfg = PORT_COUNT_RST;

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) tbl_valid[i] = 1'b0;
  end

  function automatic int lookup_mac(logic [MAC_W-1:0] mac);
    for (int i = 0; i < TBL_DEPTH; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic fwd_result_t forward_frame(frame_hdr_t hdr);
    int                src_idx;
    int                dst_idx;
    int                live;
    logic [PORTS:0]    port_bits;
    logic [MASK_W-1:0] configured;
    logic [MASK_W-1:0] ing_bit;
    fwd_result_t       res;
    res = '0;
    // port_count of PORTS or more means every port; 0 means none
    live       = (port_count_cfg >= PORTS) ? PORTS : int'(port_count_cfg);
    port_bits  = ({{PORTS{1'b0}}, 1'b1} << live) - 1'b1;
    configured = port_bits[MASK_W-1:0];
    ing_bit    = MASK_W'(1) << hdr.ingress;

    src_idx = lookup_mac(hdr.src);
    if (src_idx < 0) begin
      if (tbl_fill < TBL_DEPTH) begin
        tbl_valid[tbl_fill] = 1'b1;
        tbl_mac[tbl_fill]   = hdr.src;
        tbl_port[tbl_fill]  = hdr.ingress;
        tbl_fill++;
        res.flags.learned_new = 1'b1;
      end else begin
        res.flags.table_full = 1'b1;
      end
    end else if (tbl_port[src_idx] != hdr.ingress) begin
      tbl_port[src_idx]    = hdr.ingress;
      res.flags.port_moved = 1'b1;
    end

    dst_idx = lookup_mac(hdr.dest);
    if (dst_idx < 0) begin
      res.egress_mask = configured & ~ing_bit;          // flood
    end else begin
      res.flags.dest_known = 1'b1;
      if (tbl_port[dst_idx] == hdr.ingress)
        res.egress_mask = '0;                           // same segment, drop
      else
        res.egress_mask = configured & (MASK_W'(1) << tbl_port[dst_idx]);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus source: a pool of addresses so that sources and destinations
  // hit the table often, with fresh addresses mixed in.
  // --------------------------------------------------------------------------
  frame_hdr_t       pending_hdrs [$];
  fwd_result_t      expected_results [$];
  logic [MAC_W-1:0] mac_pool [$];
  int               hdrs_accepted = 0;
  bit               hdr_taken = 1'b0;
  int               fail_count = 0;

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic frame_hdr_t random_header(logic [CFG_W-1:0] pc);
    frame_hdr_t h;
    int         live;
    int         pick;
    live = (pc >= PORTS) ? PORTS : int'(pc);
    pick = $urandom_range(99);
    if (pick < 12 || mac_pool.size() == 0) begin
      h.src = random_mac();
      if (mac_pool.size() < POOL_MAX) mac_pool.push_back(h.src);
    end else begin
      h.src = mac_pool[$urandom_range(mac_pool.size() - 1)];
    end
    pick = $urandom_range(99);
    if (pick < 10)
      h.dest = h.src;
    else if (pick < 30)
      h.dest = random_mac();
    else
      h.dest = mac_pool[$urandom_range(mac_pool.size() - 1)];
    // mostly on live ports, so moves and unicast hits are frequent
    if (live > 0 && $urandom_range(99) < 80)
      h.ingress = PORT_W'($urandom_range(live - 1));
    else
      h.ingress = PORT_W'($urandom_range(PORTS - 1));
    return h;
  endfunction

  task automatic queue_hdr(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dest,
                           logic [PORT_W-1:0] ingress);
    frame_hdr_t h;
    h.src     = src;
    h.dest    = dest;
    h.ingress = ingress;
    pending_hdrs.push_back(h);
    if (mac_pool.size() < POOL_MAX) mac_pool.push_back(src);
  endtask

  // Sender pause: everything sent, every result back, then a scan's worth
  // of cycles so the block is surely idle before the next register write.
  // Checked at the rising edge, where in_tvalid from the driver has settled.
  task automatic drain_results();
    while (pending_hdrs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_port_count(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en      <= 1'b0;
    port_count_cfg  = value;
  endtask

  function automatic bit steady_window();
    return hdrs_accepted >= STEADY_LO && hdrs_accepted < STEADY_HI;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: driver changes at the falling edge, the accept is seen at
  // the rising edge. Each accepted transaction is run through the table.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    frame_hdr_t hdr;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || hdr_taken) begin
      if (pending_hdrs.size() != 0 && (steady_window() || $urandom_range(99) >= IDLE_PCT)) begin
        hdr = pending_hdrs.pop_front();
        in_tdata  <= IN_TDATA_W'(hdr);
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_in
    frame_hdr_t hdr;
    hdr_taken = 1'b0;
    if (rst_n && in_tvalid && in_tready === 1'b1) begin
      hdr = frame_hdr_t'(in_tdata[IN_FIELDS_W-1:0]);
      expected_results.push_back(forward_frame(hdr));
      hdrs_accepted++;
      hdr_taken = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure plus one long hold-off while the
  // sender keeps offering, so the block fills and stalls its input.
  // --------------------------------------------------------------------------
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;

  always @(negedge clk) begin : drive_out
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (!rx_hold_done && hdrs_accepted >= HOLD_AT) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_window() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin : check_out
    fwd_result_t want;
    out_flags_t  got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_flags_t'(out_tuser);
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("[%0t] unexpected result: mask=%02h flags=%04b", $realtime,
                   out_tdata, out_tuser);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata       !== want.egress_mask ||
            got.dest_known  !== want.flags.dest_known ||
            got.learned_new !== want.flags.learned_new ||
            got.port_moved  !== want.flags.port_moved ||
            got.table_full  !== want.flags.table_full) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"[%0t] mismatch: mask exp %02h got %02h, known %b/%b, ",
                      "learned %b/%b, moved %b/%b, full %b/%b"}, $realtime,
                     want.egress_mask, out_tdata,
                     want.flags.dest_known, got.dest_known,
                     want.flags.learned_new, got.learned_new,
                     want.flags.port_moved, got.port_moved,
                     want.flags.table_full, got.table_full);
        end
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] phase_ports [12] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd6, 4'd0,
                                         4'd9, 4'd2, 4'd5, 4'd8, 4'd4, 4'd7};

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;
  localparam logic [MAC_W-1:0] MAC_ALT1 = 48'hAAAA_AAAA_AAAA;
  localparam logic [MAC_W-1:0] MAC_ALT0 = 48'h5555_5555_5555;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset port count (2 ports). Learn, flood, drop on own segment,
    // station move, unconfigured ingress and unconfigured destination port.
    queue_hdr(MAC_ZERO, MAC_ONES, 3'd0);   // learn, flood to port 1
    queue_hdr(MAC_ONES, MAC_ZERO, 3'd7);   // ingress outside live ports
    queue_hdr(MAC_ZERO, MAC_ZERO, 3'd0);   // dest equals source: drop
    queue_hdr(MAC_ZERO, MAC_ONES, 3'd1);   // move; dest on dead port 7
    queue_hdr(MAC_ALT1, MAC_ALT0, 3'd3);   // flood from dead ingress
    drain_results();

    // No ports: every mask must be zero
    write_port_count(4'd0);
    queue_hdr(MAC_ALT0, MAC_ALT1, 3'd2);
    queue_hdr(48'h1234_5678_9ABC, 48'hDEAD_BEEF_0001, 3'd6);
    drain_results();

    // Out-of-range count saturates to all ports
    write_port_count(4'd15);
    queue_hdr(48'h0DEF_0123_4567, random_mac(), 3'd4);  // flood 8'hEF
    queue_hdr(MAC_ALT1, MAC_ZERO, 3'd5);               // move, unicast
    queue_hdr(MAC_ONES, MAC_ALT1, 3'd7);               // known, no move
    queue_hdr(MAC_ALT0, MAC_ALT0, 3'd2);               // self, drop
    drain_results();

    // Single port
    write_port_count(4'd1);
    queue_hdr(MAC_ZERO, random_mac(), 3'd0);   // flood with nothing left
    queue_hdr(random_mac(), MAC_ZERO, 3'd1);   // unicast to port 0
    drain_results();

    // Random phases; the table fills part-way through and then stays full
    foreach (phase_ports[p]) begin
      write_port_count(phase_ports[p]);
      repeat (RAND_PER_PHASE) pending_hdrs.push_back(random_header(phase_ports[p]));
      drain_results();
    end

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      fail_count += expected_results.size();
    end
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
